// File: hw/rtl/contiguous_block_allocator_core_assert.svh
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
// Clocked assertion, reset low disables.
`define CBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true at a clock edge.
`define CBA_ASSERT_NEVER(label, cond, msg) \
  `CBA_ASSERT(label, !(cond), msg)
`endif

// File: hw/rtl/cba_pkg.sv
`default_nettype none
package cba_pkg;
  localparam int BLOCK_COUNT = 256;
  localparam int BLOCK_BYTES = 4096;
  localparam int IDX_W = $clog2(BLOCK_COUNT);
  localparam int LNK_W = $clog2(BLOCK_COUNT + 1);
  localparam int SHIFT = $clog2(BLOCK_BYTES);
  localparam logic [LNK_W-1:0] NULL_LINK = LNK_W'(BLOCK_COUNT);
  localparam logic [31:0] BASE_RESET = 32'h9400_0000;
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE = 1'b1;
endpackage
`default_nettype wire

// File: hw/rtl/cba_mem.sv
`default_nettype none
// Link table memory: one write port, one registered read port.
module cba_mem
  import cba_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire logic [LNK_W-1:0] wdata,
  input  wire logic [IDX_W-1:0] raddr,
  output logic      [LNK_W-1:0] rdata
);
  logic [LNK_W-1:0] mem [BLOCK_COUNT];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/contiguous_block_allocator_core.sv
`default_nettype none
// First-fit allocator over BLOCK_COUNT blocks of BLOCK_BYTES bytes. After reset the block
// builds the link tables and clears the run marks, with busy high. A request then visits
// each list entry in a read, a wait and a check state, since link reads come one at a time
// from a registered memory port: allocate walks the free list and then walks the chosen
// run again to mark it, free walks the used list and then the released run. Unlink,
// append and result steps come on top. busy is high for the whole request; the result
// shows for a single cycle on out_valid, in the first cycle with busy low, and cannot
// be stalled.
`include "contiguous_block_allocator_core_assert.svh"
module contiguous_block_allocator_core
  import cba_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_action,
  input  wire logic [30:0] in_size_bytes,
  input  wire logic [31:0] in_free_address,
  output logic             out_valid,
  output logic             out_status,
  output logic [31:0]      out_block_address,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_ARD, S_AWAIT, S_ACHK, S_MARK, S_MRD, S_MWAIT,
    S_DT0, S_DT1, S_DT2, S_AT0, S_AT1,
    S_FRD, S_FWAIT, S_FCHK, S_RWALK, S_RRD, S_RWAIT, S_DONE
  } state_t;

  state_t state_r;
  logic [31:0] base_r;
  logic [IDX_W-1:0] initc_r;
  logic [LNK_W-1:0] fhead_r, ftail_r, uhead_r, utail_r;
  logic [LNK_W-1:0] cur_r, start_r, last_r, first_r, k_r, p_r, n_r;
  logic [IDX_W:0] len_r;
  logic [31:0] need_r, addr_r;
  logic act_r, fail_r, lenz_r;

  logic run_mem [BLOCK_COUNT];
  logic run_rd_r;
  logic run_we, run_wd;
  logic [IDX_W-1:0] run_wa, run_ra;

  logic nwe, pwe;
  logic [IDX_W-1:0] nwa, pwa, nra, pra;
  logic [LNK_W-1:0] nwd, pwd, nrd, prd;

  cba_mem u_next (.clk, .we(nwe), .waddr(nwa), .wdata(nwd), .raddr(nra), .rdata(nrd));
  cba_mem u_prev (.clk, .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(prd));

  assign cfg_pready = 1'b1;
  assign cfg_prdata = base_r;
  assign busy = (state_r != S_IDLE);

  function automatic logic isb(input logic [LNK_W-1:0] v);
    return v < NULL_LINK;
  endfunction
  function automatic logic [IDX_W-1:0] ix(input logic [LNK_W-1:0] v);
    return v[IDX_W-1:0];
  endfunction

  logic [31:0] cur_addr;
  assign cur_addr = base_r + (32'(cur_r) << SHIFT);

  always_comb begin
    nwe = 1'b0; pwe = 1'b0;
    nwa = ix(cur_r); pwa = ix(cur_r); nwd = NULL_LINK; pwd = NULL_LINK;
    nra = ix(cur_r); pra = ix(cur_r);
    run_we = 1'b0; run_wa = ix(k_r); run_wd = 1'b0;
    run_ra = (state_r == S_FCHK) ? ix(cur_r) : ix(nrd);
    unique case (state_r)
      S_INIT: begin
        nwe = 1'b1; pwe = 1'b1; nwa = initc_r; pwa = initc_r;
        nwd = (32'(initc_r) == BLOCK_COUNT - 1) ? NULL_LINK : LNK_W'(initc_r) + 1'b1;
        pwd = (initc_r == '0) ? NULL_LINK : LNK_W'(initc_r) - 1'b1;
        run_we = 1'b1; run_wa = initc_r;
      end
      S_MARK: begin run_we = 1'b1; run_wd = (k_r != last_r); end
      S_RWALK: run_we = 1'b1;
      S_MRD, S_RRD: nra = ix(k_r);
      S_DT0: begin nra = ix(last_r); pra = ix(first_r); end
      S_DT2: begin
        // unlink [first,last]; head/tail fixes are registers
        if (first_r != (act_r ? uhead_r : fhead_r) && isb(p_r)) begin
          nwe = 1'b1; nwa = ix(p_r); nwd = n_r;
        end
        if (last_r != (act_r ? utail_r : ftail_r) && isb(n_r)) begin
          pwe = 1'b1; pwa = ix(n_r); pwd = p_r;
        end
      end
      S_AT0: begin
        pwe = 1'b1; pwa = ix(first_r);
        if (isb(act_r ? ftail_r : utail_r)) begin
          pwd = act_r ? ftail_r : utail_r;
          nwe = 1'b1; nwa = ix(act_r ? ftail_r : utail_r); nwd = first_r;
        end
      end
      S_AT1: begin nwe = 1'b1; nwa = ix(last_r); nwd = NULL_LINK; end
      default: ;
    endcase
  end

  // run marks: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (run_we) run_mem[run_wa] <= run_wd;
    run_rd_r <= run_mem[run_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT; initc_r <= '0; base_r <= BASE_RESET;
      fhead_r <= '0; ftail_r <= LNK_W'(BLOCK_COUNT - 1);
      uhead_r <= NULL_LINK; utail_r <= NULL_LINK;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state_r == S_DONE);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) base_r <= cfg_pwdata;
      unique case (state_r)
        S_INIT: begin
          initc_r <= initc_r + 1'b1;
          if (32'(initc_r) == BLOCK_COUNT - 1) state_r <= S_IDLE;
        end
        S_IDLE: if (start) begin
          act_r <= in_action; addr_r <= in_free_address;
          need_r <= (32'(in_size_bytes) + 32'(BLOCK_BYTES - 1)) >> SHIFT;
          len_r <= '0; lenz_r <= 1'b1;
          if (in_action == ACT_ALLOC) begin
            cur_r <= fhead_r;
            state_r <= (in_size_bytes == '0) ? S_DONE : S_ACHK;
            fail_r <= (in_size_bytes == '0);
          end else begin
            cur_r <= uhead_r; fail_r <= 1'b0; state_r <= S_FCHK;
          end
        end
        S_ACHK: begin
          if (!isb(cur_r)) begin fail_r <= 1'b1; state_r <= S_DONE; end
          else begin
            if (!lenz_r && cur_r == last_r + 1'b1) len_r <= len_r + 1'b1;
            else begin start_r <= cur_r; len_r <= {{IDX_W{1'b0}}, 1'b1}; end
            lenz_r <= 1'b0; last_r <= cur_r;
            if (((!lenz_r && cur_r == last_r + 1'b1) ? 32'(len_r) + 1 : 32'd1) >= need_r) begin
              k_r <= (!lenz_r && cur_r == last_r + 1'b1) ? start_r : cur_r;
              first_r <= (!lenz_r && cur_r == last_r + 1'b1) ? start_r : cur_r;
              state_r <= S_MARK;
            end else state_r <= S_ARD;
          end
        end
        S_ARD: state_r <= S_AWAIT;
        S_AWAIT: begin cur_r <= nrd; state_r <= S_ACHK; end
        S_MARK: begin
          if (k_r == last_r) state_r <= S_DT0;
          else state_r <= S_MRD;
        end
        S_MRD: state_r <= S_MWAIT;
        S_MWAIT: begin k_r <= nrd; state_r <= S_MARK; end
        S_FCHK: begin
          if (!isb(cur_r)) begin fail_r <= 1'b1; state_r <= S_DONE; end
          else if (cur_addr == addr_r) begin
            first_r <= cur_r; k_r <= cur_r; state_r <= S_RWALK;
          end else state_r <= S_FRD;
        end
        S_FRD: state_r <= S_FWAIT;
        S_FWAIT: begin cur_r <= nrd; state_r <= S_FCHK; end
        S_RWALK: begin
          if (!run_rd_r || k_r == utail_r) begin last_r <= k_r; state_r <= S_DT0; end
          else state_r <= S_RRD;
        end
        S_RRD: state_r <= S_RWAIT;
        S_RWAIT: begin
          if (!isb(nrd)) begin last_r <= k_r; state_r <= S_DT0; end
          else begin k_r <= nrd; state_r <= S_RWALK; end
        end
        S_DT0: state_r <= S_DT1;
        S_DT1: begin n_r <= nrd; p_r <= prd; state_r <= S_DT2; end
        S_DT2: begin
          if (act_r) begin
            if (first_r == uhead_r) uhead_r <= n_r;
            if (last_r == utail_r) utail_r <= p_r;
          end else begin
            if (first_r == fhead_r) fhead_r <= n_r;
            if (last_r == ftail_r) ftail_r <= p_r;
          end
          state_r <= S_AT0;
        end
        S_AT0: begin
          if (act_r) begin if (!isb(ftail_r)) fhead_r <= first_r; end
          else begin if (!isb(utail_r)) uhead_r <= first_r; end
          state_r <= S_AT1;
        end
        S_AT1: begin
          if (act_r) ftail_r <= last_r; else utail_r <= last_r;
          addr_r <= base_r + (32'(first_r) << SHIFT);
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_status <= fail_r;
          out_block_address <= fail_r ? 32'd0 : addr_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_INIT;
      endcase
    end
  end

  `CBA_ASSERT(a_done_valid, (state_r == S_DONE) |=> out_valid, "result strobe missing")
  `CBA_ASSERT(a_valid_idle, out_valid |-> (state_r == S_IDLE), "result while not idle")
  `CBA_ASSERT(a_fail_zero, (out_valid && out_status) |-> (out_block_address == 32'd0),
  "failure with nonzero address")
  `CBA_ASSERT_NEVER(a_valid_busy, out_valid && busy, "result while busy")
endmodule
`default_nettype wire
